### hdl/laba_pkg.sv
// Package for the lifetime aliasing block allocator: opcodes, status codes,
// controller states, the bytes-per-pixel table and the command/status structs.
// No dependencies.
package laba_pkg;

   localparam int unsigned SLOTS_DEFAULT = 64;
   localparam logic [53:0] BUDGET_RESET  = 54'd268435456;
   localparam logic [47:0] SIZE_MAX48    = 48'hFFFF_FFFF_0000;
   localparam logic [53:0] MAX54         = {54{1'b1}};

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_FRAME   = 2'd2;
   localparam logic [1:0] OP_RESET   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   localparam logic CSR_ALIAS_EN = 1'b0;
   localparam logic CSR_BUDGET   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_ROUND,
      S_SCAN, S_WAIT, S_COMMIT, S_OUT
   } state_type;

   typedef struct packed {
      logic load;      // capture request
      logic mul_step;  // one serial multiply
      logic round;     // align and saturate size
      logic scan_start;
      logic scan_step;
      logic commit;    // apply op to state
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic       scan_done;
      logic       full;
   } sts_type;

   function automatic logic [4:0] bpp(input logic [3:0] fmt);
      case (fmt)
         4'd2, 4'd7, 4'd11: bpp = 5'd8;
         4'd3:              bpp = 5'd16;
         4'd4:              bpp = 5'd2;
         default:           bpp = 5'd4;
      endcase
   endfunction

endpackage

### hdl/laba_ctrl.sv
// Controller state machine of the allocator: sequences the size multiplies,
// the slot scan and the commit. Depends on laba_pkg.
module laba_ctrl import laba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    rsp_free,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_MUL1;
         S_MUL1:   state_in = S_MUL2;
         S_MUL2:   state_in = S_MUL3;
         S_MUL3:   state_in = S_MUL4;
         S_MUL4:   state_in = S_ROUND;
         S_ROUND:  state_in = S_SCAN;
         S_SCAN:   if (sts.scan_done) state_in = S_WAIT;
         S_WAIT:   state_in = S_COMMIT;
         S_COMMIT: state_in = S_OUT;
         S_OUT:    if (rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE:  begin
            req_tready = 1'b1;
            cmd.load = req_tvalid;
         end
         S_MUL1, S_MUL2, S_MUL3, S_MUL4: cmd.mul_step = 1'b1;
         S_ROUND: begin
            cmd.round = 1'b1;
            cmd.scan_start = 1'b1;
         end
         S_SCAN:   cmd.scan_step = 1'b1;
         S_COMMIT: cmd.commit = 1'b1;
         S_OUT:    cmd.out_load = rsp_free;
         default:  cmd = '0;
      endcase
   end
endmodule

### hdl/laba_dp.sv
// Datapath of the allocator: request registers, serial size multiplier,
// slot memories, scan, statistics and result word. Depends on laba_pkg.
module laba_dp import laba_pkg::*; #(
   parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [119:0]  req_tdata,
   input  logic          alias_en,
   input  logic [53:0]   budget,
   input  cmd_type       cmd,
   output sts_type       sts,
   output logic [303:0]  rsp_word
);
   localparam int unsigned IW = $clog2(SLOTS);
   localparam int unsigned CW = $clog2(SLOTS + 1);

   // request fields
   logic [1:0]  op_ff;
   logic [14:0] w_ff, h_ff;
   logic [4:0]  smp_ff;
   logic [11:0] lay_ff;
   logic [15:0] fp_ff, lp_ff;
   logic [31:0] rid_ff;
   logic [63:0] prod_ff;
   logic [1:0]  mstep_ff;
   logic [47:0] size_ff;

   // slot memories, one read port each
   logic [31:0] mem_id    [SLOTS];
   logic [15:0] mem_first [SLOTS];
   logic [15:0] mem_last  [SLOTS];
   logic [47:0] mem_bytes [SLOTS];
   logic [31:0] mem_block [SLOTS];
   logic        mem_busy  [SLOTS];
   logic [31:0] rd_id_ff, rd_block_ff;
   logic [15:0] rd_first_ff, rd_last_ff;
   logic [47:0] rd_bytes_ff;
   logic        rd_busy_ff;

   logic [CW-1:0] cnt_ff, rptr_ff;
   logic [IW-1:0] hit_idx_ff, cur_idx_ff;
   logic          rd_vld_ff, found_ff;
   logic [31:0]   fblock_ff;

   logic [31:0] idc_ff, aliasc_ff, recyc_ff;
   logic [53:0] used_ff, unal_ff;
   logic [CW-1:0] busyc_ff, peak_ff;

   logic [1:0]  o_status;
   logic [31:0] o_handle, o_block;
   logic        o_aliased, o_over;
   logic [47:0] o_size;
   logic [303:0] rsp_ff;

   // serial multiply: pick the operand, one shared multiplier
   logic [14:0] mul_op;
   logic [63:0] mul_in;
   always_comb begin
      case (mstep_ff)
         2'd0:    mul_op = h_ff;
         2'd1:    mul_op = 15'(smp_ff);
         2'd2:    mul_op = 15'(lay_ff);
         default: mul_op = 15'd1;
      endcase
   end
   // running product stays below 2^40 until the layer step
   assign mul_in = (mstep_ff == 2'd3) ? prod_ff
                                      : 64'(55'(prod_ff[39:0]) * 55'(mul_op));

   // product fits 5+15+15+5+12 = 52 bits
   logic [52:0] rnd;
   assign rnd = prod_ff[52:0] + 53'd65535;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_tdata[1:0];
         w_ff    <= req_tdata[20:6];
         h_ff    <= req_tdata[35:21];
         smp_ff  <= req_tdata[40:36];
         lay_ff  <= req_tdata[52:41];
         fp_ff   <= req_tdata[68:53];
         lp_ff   <= req_tdata[84:69];
         rid_ff  <= req_tdata[116:85];
         prod_ff <= 64'(bpp(req_tdata[5:2])) * 64'(req_tdata[20:6]);
         mstep_ff <= 2'd0;
      end else if (cmd.mul_step) begin
         prod_ff  <= mul_in;
         mstep_ff <= mstep_ff + 2'd1;
      end
      if (cmd.round)
         size_ff <= (rnd[52:48] != '0) ? SIZE_MAX48 : {rnd[47:16], 16'd0};
   end

   // scan: read slot rptr into the read registers, evaluate it in the next cycle
   logic scan_end;
   assign scan_end = (rptr_ff >= cnt_ff) || found_ff;
   logic cand_hit, rel_hit;
   assign cand_hit = !(rd_last_ff >= fp_ff && rd_first_ff <= lp_ff) && rd_bytes_ff >= size_ff;
   assign rel_hit  = rd_id_ff == rid_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         rptr_ff   <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else if (cmd.scan_step || cmd.commit || !cmd.load) begin
         if (cmd.scan_step && !scan_end) begin
            rptr_ff   <= rptr_ff + 1'b1;
            rd_vld_ff <= 1'b1;
            cur_idx_ff <= rptr_ff[IW-1:0];
         end else begin
            rd_vld_ff <= 1'b0;
         end
         if (rd_vld_ff && !found_ff) begin
            if ((op_ff == OP_ALLOC && alias_en && cand_hit) ||
                (op_ff == OP_RELEASE && rel_hit)) begin
               found_ff   <= 1'b1;
               hit_idx_ff <= cur_idx_ff;
               fblock_ff  <= rd_block_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_id_ff    <= mem_id[rptr_ff[IW-1:0]];
      rd_first_ff <= mem_first[rptr_ff[IW-1:0]];
      rd_last_ff  <= mem_last[rptr_ff[IW-1:0]];
      rd_bytes_ff <= mem_bytes[rptr_ff[IW-1:0]];
      rd_block_ff <= mem_block[rptr_ff[IW-1:0]];
      rd_busy_ff  <= mem_busy[hit_idx_ff];
   end

   assign sts.full      = cnt_ff >= CW'(SLOTS);
   assign sts.scan_done = scan_end && !rd_vld_ff;

   // commit
   logic [54:0] used_sum, unal_sum;
   logic        do_alloc, alias_now;
   logic [31:0] idc_nx;
   logic [CW-1:0] busy_nx;
   assign used_sum  = {1'b0, used_ff} + 55'(size_ff);
   assign unal_sum  = {1'b0, unal_ff} + 55'(size_ff);
   assign do_alloc  = op_ff == OP_ALLOC && !sts.full;
   assign alias_now = found_ff;
   assign idc_nx    = (idc_ff + 32'd1 == 32'd0) ? 32'd1 : idc_ff + 32'd1;
   assign busy_nx   = busyc_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.commit && do_alloc) begin
         mem_id[cnt_ff[IW-1:0]]    <= idc_ff;
         mem_first[cnt_ff[IW-1:0]] <= fp_ff;
         mem_last[cnt_ff[IW-1:0]]  <= lp_ff;
         mem_bytes[cnt_ff[IW-1:0]] <= size_ff;
         mem_block[cnt_ff[IW-1:0]] <= alias_now ? fblock_ff : idc_ff;
         mem_busy[cnt_ff[IW-1:0]]  <= 1'b1;
      end else if (cmd.commit && op_ff == OP_RELEASE && found_ff) begin
         mem_busy[hit_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; idc_ff <= 32'd1; used_ff <= '0; unal_ff <= '0;
         aliasc_ff <= '0; busyc_ff <= '0; peak_ff <= '0; recyc_ff <= '0;
      end else if (cmd.commit) begin
         o_status <= ST_OK; o_handle <= '0; o_block <= '0;
         o_aliased <= 1'b0; o_size <= '0; o_over <= 1'b0;
         case (op_ff)
            OP_ALLOC: begin
               o_size <= size_ff;
               if (sts.full) begin
                  o_status <= ST_FULL;
               end else begin
                  o_handle <= idc_ff;
                  idc_ff   <= idc_nx;
                  unal_ff  <= unal_sum[54] ? MAX54 : unal_sum[53:0];
                  if (alias_now) begin
                     o_aliased <= 1'b1;
                     o_block   <= fblock_ff;
                     aliasc_ff <= aliasc_ff + 32'd1;
                  end else begin
                     o_over  <= used_sum > {1'b0, budget};
                     o_block <= idc_ff;
                     used_ff <= used_sum[54] ? MAX54 : used_sum[53:0];
                  end
                  cnt_ff   <= cnt_ff + 1'b1;
                  busyc_ff <= busy_nx;
                  if (busy_nx > peak_ff) peak_ff <= busy_nx;
               end
            end
            OP_RELEASE: begin
               if (!found_ff) o_status <= ST_NOTFOUND;
               else if (rd_busy_ff) busyc_ff <= busyc_ff - 1'b1;
            end
            OP_FRAME: begin
               recyc_ff <= recyc_ff + 32'(busyc_ff);
               cnt_ff <= '0; busyc_ff <= '0; used_ff <= '0; unal_ff <= '0;
            end
            default: begin
               cnt_ff <= '0; idc_ff <= 32'd1; used_ff <= '0; unal_ff <= '0;
               aliasc_ff <= '0; busyc_ff <= '0; peak_ff <= '0; recyc_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load)
         rsp_ff <= {2'd0, recyc_ff, 7'(peak_ff), unal_ff, used_ff, aliasc_ff,
                    7'(busyc_ff), o_over, o_size, o_aliased, o_block, o_handle,
                    o_status};
   end
   assign rsp_word = rsp_ff;
endmodule

### hdl/lifetime_aliasing_block_allocator.sv
// Top level of the lifetime aliasing block allocator: configuration registers,
// output register and the controller/datapath pair. Depends on laba_pkg,
// laba_ctrl and laba_dp.
//
// One request word is taken at a time. The result word is loaded only once
// the result register is no longer held by a stalled receiver. The steps,
// in order: the accept, the serial multiplies S_MUL1 to S_MUL4 through one
// shared multiplier, rounding, a scan of the stored slots one per cycle
// through a single memory read port (allocate stops at the first reusable
// block, release at the first matching id), a wait state to read the busy
// flag of the hit, the commit and the load of the result register.
// The result word is held in its own register while the next request enters.
// Configuration: index 0 aliasing enable, index 1 memory budget; write only
// while idle. The slot table needs no clearing after reset: only entries
// below the fill count are read.
module lifetime_aliasing_block_allocator import laba_pkg::*; #(
   parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // opcode, format, width, height, samples, array_layers, first_pass,
   // last_pass, release_id (low bit up), zero filled
   input  logic [119:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // status, handle_id, memory_block, aliased, size_bytes, over_budget,
   // active_count, aliased_total, memory_used, memory_unaliased, peak_active,
   // recycled_total (low bit up), zero filled
   output logic [303:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [53:0]  csr_data
);
   cmd_type cmd;
   sts_type sts;
   logic    alias_en_ff;
   logic [53:0] budget_ff;
   logic    rsp_valid_ff;
   logic    rsp_free;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         alias_en_ff <= 1'b1;
         budget_ff   <= BUDGET_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ALIAS_EN: alias_en_ff <= csr_data[0];
            CSR_BUDGET:   budget_ff   <= csr_data;
            default:      budget_ff   <= budget_ff;
         endcase
      end
   end

   // output register frees when empty or being taken
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   always_ff @(posedge clock) begin
      if (reset)             rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready)   rsp_valid_ff <= 1'b0;
   end
   assign rsp_tvalid = rsp_valid_ff;

   laba_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_free, .sts, .cmd
   );

   laba_dp #(.SLOTS(SLOTS)) u_dp (
      .clock, .reset, .req_tdata, .alias_en(alias_en_ff), .budget(budget_ff),
      .cmd, .sts, .rsp_word(rsp_tdata)
   );
endmodule

### hdl/laba_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on the top level's ports only.
module laba_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [303:0] rsp_tdata
);
   // no response leaves the reset cycle
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");
   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");
   // accept is followed by a busy cycle
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken at once");
   // status code in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad status");
endmodule

bind lifetime_aliasing_block_allocator laba_checker u_laba_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata
);

### sim/tb_lifetime_aliasing_block_allocator.sv
// Self-checking testbench for lifetime_aliasing_block_allocator: drives request
// words, predicts every response word and compares them field by field.
// Depends on laba_pkg and the allocator RTL.
module tb_lifetime_aliasing_block_allocator import laba_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOTS = 64;

   // request fields, last field in the highest bits
   typedef struct packed {
      logic [31:0] release_id;
      logic [15:0] last_pass;
      logic [15:0] first_pass;
      logic [11:0] array_layers;
      logic [4:0]  samples;
      logic [14:0] height;
      logic [14:0] width;
      logic [3:0]  format;
      logic [1:0]  opcode;
   } alloc_req_type;

   // response fields, last field in the highest bits
   typedef struct packed {
      logic [31:0] recycled_total;
      logic [6:0]  peak_active;
      logic [53:0] memory_unaliased;
      logic [53:0] memory_used;
      logic [31:0] aliased_total;
      logic [6:0]  active_count;
      logic        over_budget;
      logic [47:0] size_bytes;
      logic        aliased;
      logic [31:0] memory_block;
      logic [31:0] handle_id;
      logic [1:0]  status;
   } alloc_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [119:0] req_tdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [303:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [53:0]  csr_data = '0;

   lifetime_aliasing_block_allocator u_top (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the allocator: configuration, slot table and statistics.
   logic        alias_en;
   logic [53:0] budget;
   int unsigned fill_count;
   logic [31:0] tbl_id    [NSLOTS];
   logic [15:0] tbl_first [NSLOTS];
   logic [15:0] tbl_last  [NSLOTS];
   logic [47:0] tbl_bytes [NSLOTS];
   logic [31:0] tbl_block [NSLOTS];
   logic        tbl_busy  [NSLOTS];
   logic [31:0] next_id;
   logic [53:0] fresh_bytes;
   logic [53:0] plain_bytes;
   logic [31:0] alias_hits;
   int unsigned live_count;
   int unsigned live_peak;
   logic [31:0] recycled;

   alloc_rsp_type expected_rsp[$];
   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   function automatic void clear_stats();
      fill_count = 0;
      next_id = 32'd1;
      fresh_bytes = '0;
      plain_bytes = '0;
      alias_hits = '0;
      live_count = 0;
      live_peak = 0;
      recycled = '0;
   endfunction

   function automatic logic [53:0] add_clamped(logic [53:0] a, logic [47:0] b);
      logic [63:0] s;
      s = 64'(a) + 64'(b);
      return (s > 64'(MAX54)) ? MAX54 : s[53:0];
   endfunction

   function automatic logic [47:0] footprint(alloc_req_type r);
      logic [63:0] s;
      logic [63:0] unit;
      case (r.format)
         4'd2, 4'd7, 4'd11: unit = 64'd8;
         4'd3:              unit = 64'd16;
         4'd4:              unit = 64'd2;
         default:           unit = 64'd4;
      endcase
      s = unit * 64'(r.width) * 64'(r.height) * 64'(r.samples) * 64'(r.array_layers);
      s = (s + 64'd65535) & ~64'd65535;
      return (s > 64'(SIZE_MAX48)) ? SIZE_MAX48 : s[47:0];
   endfunction

   // Apply one request to the predictor and return the response it must give.
   function automatic alloc_rsp_type allocator_step(alloc_req_type r);
      alloc_rsp_type o;
      logic [31:0] id;
      logic        hit;
      o = '0;
      hit = 1'b0;
      case (r.opcode)
         OP_ALLOC: begin
            o.size_bytes = footprint(r);
            if (fill_count >= NSLOTS) begin
               o.status = ST_FULL;
            end else begin
               id = next_id;
               next_id = next_id + 32'd1;
               if (next_id == 32'd0) next_id = 32'd1;
               plain_bytes = add_clamped(plain_bytes, o.size_bytes);
               if (alias_en) begin
                  for (int i = 0; i < fill_count; i++) begin
                     if (tbl_last[i] >= r.first_pass && tbl_first[i] <= r.last_pass)
                        continue;
                     if (tbl_bytes[i] >= o.size_bytes) begin
                        o.memory_block = tbl_block[i];
                        hit = 1'b1;
                        break;
                     end
                  end
               end
               if (hit) begin
                  o.aliased = 1'b1;
                  alias_hits = alias_hits + 32'd1;
               end else begin
                  // budget test uses the unclamped sum
                  o.over_budget = (64'(fresh_bytes) + 64'(o.size_bytes)) > 64'(budget);
                  o.memory_block = id;
                  fresh_bytes = add_clamped(fresh_bytes, o.size_bytes);
               end
               o.handle_id = id;
               tbl_id[fill_count] = id;
               tbl_first[fill_count] = r.first_pass;
               tbl_last[fill_count] = r.last_pass;
               tbl_bytes[fill_count] = o.size_bytes;
               tbl_block[fill_count] = o.memory_block;
               tbl_busy[fill_count] = 1'b1;
               fill_count++;
               live_count++;
               if (live_count > live_peak) live_peak = live_count;
            end
         end
         OP_RELEASE: begin
            o.status = ST_NOTFOUND;
            for (int i = 0; i < fill_count; i++) begin
               if (tbl_id[i] == r.release_id) begin
                  o.status = ST_OK;
                  if (tbl_busy[i]) begin
                     tbl_busy[i] = 1'b0;
                     live_count--;
                  end
                  break;
               end
            end
         end
         OP_FRAME: begin
            recycled = recycled + 32'(live_count);
            fill_count = 0;
            live_count = 0;
            fresh_bytes = '0;
            plain_bytes = '0;
         end
         default: clear_stats();
      endcase
      o.active_count = 7'(live_count);
      o.aliased_total = alias_hits;
      o.memory_used = fresh_bytes;
      o.memory_unaliased = plain_bytes;
      o.peak_active = 7'(live_peak);
      o.recycled_total = recycled;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Receiver: stall at random, check each accepted response word.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      alloc_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(alloc_rsp_type)-1:0];
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected word", 64'(got.status), 64'd0);
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.handle_id !== want.handle_id)
               report_mismatch("handle_id", 64'(got.handle_id), 64'(want.handle_id));
            if (got.memory_block !== want.memory_block)
               report_mismatch("memory_block", 64'(got.memory_block), 64'(want.memory_block));
            if (got.aliased !== want.aliased)
               report_mismatch("aliased", 64'(got.aliased), 64'(want.aliased));
            if (got.size_bytes !== want.size_bytes)
               report_mismatch("size_bytes", 64'(got.size_bytes), 64'(want.size_bytes));
            if (got.over_budget !== want.over_budget)
               report_mismatch("over_budget", 64'(got.over_budget), 64'(want.over_budget));
            if (got.active_count !== want.active_count)
               report_mismatch("active_count", 64'(got.active_count), 64'(want.active_count));
            if (got.aliased_total !== want.aliased_total)
               report_mismatch("aliased_total", 64'(got.aliased_total),
                               64'(want.aliased_total));
            if (got.memory_used !== want.memory_used)
               report_mismatch("memory_used", 64'(got.memory_used), 64'(want.memory_used));
            if (got.memory_unaliased !== want.memory_unaliased)
               report_mismatch("memory_unaliased", 64'(got.memory_unaliased),
                               64'(want.memory_unaliased));
            if (got.peak_active !== want.peak_active)
               report_mismatch("peak_active", 64'(got.peak_active), 64'(want.peak_active));
            if (got.recycled_total !== want.recycled_total)
               report_mismatch("recycled_total", 64'(got.recycled_total),
                               64'(want.recycled_total));
         end
      end
   end

   // Send one request word; take a random gap first, then hold until accepted.
   // Valid stays high between back-to-back words so it is never dropped and
   // raised in the same step.
   task automatic send_word(alloc_req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= 120'(r);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_rsp = {expected_rsp, allocator_step(r)};
   endtask

   // Drop valid and wait until every response has come, plus the item latency.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (NSLOTS + 20) @(posedge clock);
   endtask

   // Write one register; only called while idle.
   task automatic write_csr(logic idx, logic [53:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_ALIAS_EN) alias_en = value[0];
      else budget = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic alloc_req_type make_alloc(int w, int h, int s, int l, int fp, int lp);
      alloc_req_type r;
      r = '0;
      r.opcode = OP_ALLOC;
      r.format = 4'($urandom_range(15));
      r.width = 15'(w);
      r.height = 15'(h);
      r.samples = 5'(s);
      r.array_layers = 12'(l);
      r.first_pass = 16'(fp);
      r.last_pass = 16'(lp);
      r.release_id = $urandom;  // ignored by allocate
      return r;
   endfunction

   function automatic alloc_req_type make_simple(logic [1:0] op, logic [31:0] rid);
      alloc_req_type r;
      r = alloc_req_type'(117'({$urandom, $urandom, $urandom, $urandom}));
      r.opcode = op;
      r.release_id = rid;
      return r;
   endfunction

   // Field extremes, every opcode, huge size, zero size, release cases.
   task automatic test_directed();
      alloc_req_type r;
      send_word(make_alloc(16384, 16384, 16, 2048, 0, 65535));  // large size, below saturation
      r = make_alloc(32767, 32767, 31, 4095, 65535, 0);          // inverted range
      r.format = 4'd3;
      send_word(r);
      send_word(make_alloc(0, 0, 0, 0, 10, 20));                 // zero size
      send_word(make_alloc(1, 1, 1, 1, 30, 40));                 // aliases the inverted-range slot
      send_word(make_alloc(64, 64, 1, 1, 1, 2));
      send_word(make_alloc(64, 64, 1, 1, 5, 6));                 // reuse non-overlapping
      send_word(make_simple(OP_RELEASE, next_id - 32'd1));
      send_word(make_simple(OP_RELEASE, next_id - 32'd1));       // already released
      send_word(make_simple(OP_RELEASE, 32'hFFFF_FFFF));         // not found
      send_word(make_simple(OP_RELEASE, 32'd0));
      send_word(make_alloc(64, 64, 1, 1, 1, 2));                 // aliases the inverted-range slot again
      send_word(make_simple(OP_FRAME, 32'd0));
      send_word(make_simple(OP_FRAME, 32'd0));                   // empty frame
      send_word(make_alloc(8, 8, 2, 3, 0, 0));
      send_word(make_simple(OP_RESET, $urandom));
      send_word(make_simple(OP_RELEASE, 32'd1));
      for (int f = 0; f < 16; f++) begin
         r = make_alloc(16, 16, 1, 1, 100, 100);
         r.format = 4'(f);
         send_word(r);
      end
      drain();
   endtask

   // Fill the table, request two more slots than it holds, then one more after a release.
   task automatic test_table_full();
      send_word(make_simple(OP_FRAME, 32'd0));
      for (int i = 0; i <= NSLOTS + 1; i++)
         send_word(make_alloc($urandom_range(1, 300), $urandom_range(1, 300), 1, 1,
                              $urandom_range(0, 20), $urandom_range(0, 20)));
      send_word(make_simple(OP_RELEASE, next_id - 32'd3));
      send_word(make_alloc(4, 4, 1, 1, 0, 0));                   // still full
      send_word(make_simple(OP_FRAME, 32'd0));
      drain();
   endtask

   // Mostly well-formed allocate/release traffic with frame starts, plus noise.
   task automatic test_random(int count, int idle_pct, int stall_pct);
      alloc_req_type r;
      int         pick, fp;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         // hold off once per phase until the pipe is empty
         if (n == count / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (expected_rsp.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(99);
         if (pick < 52) begin
            fp = $urandom_range(0, 24);
            r = make_alloc($urandom_range(1, 400), $urandom_range(1, 400),
                           $urandom_range(1, 4), $urandom_range(1, 3),
                           fp, fp + $urandom_range(0, 6));
            if ($urandom_range(19) == 0) r.last_pass = 16'($urandom_range(0, 24));
         end else if (pick < 57) begin
            r = make_simple(OP_ALLOC, $urandom);
         end else if (pick < 86) begin
            r = make_simple(OP_RELEASE, next_id - 32'($urandom_range(1, 70)));
         end else if (pick < 91) begin
            r = make_simple(OP_RELEASE, $urandom);
         end else if (pick < 98) begin
            r = make_simple(OP_FRAME, $urandom);
         end else begin
            r = make_simple(OP_RESET, $urandom);
         end
         send_word(r);
      end
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      alias_en = 1'b1;
      budget = BUDGET_RESET;
      clear_stats();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      write_csr(CSR_ALIAS_EN, 54'd0);
      write_csr(CSR_BUDGET, 54'd0);
      test_table_full();
      write_csr(CSR_ALIAS_EN, 54'({$urandom, $urandom}) | 54'd1);
      write_csr(CSR_BUDGET, MAX54);
      test_directed();

      write_csr(CSR_BUDGET, BUDGET_RESET);
      test_random(455, 0, 0);
      write_csr(CSR_ALIAS_EN, 54'd0);
      write_csr(CSR_BUDGET, 54'($urandom_range(1 << 20, 1 << 24)));
      test_random(455, 68, 0);
      write_csr(CSR_ALIAS_EN, 54'({$urandom, $urandom}) | 54'd1);
      write_csr(CSR_BUDGET, 54'({$urandom, $urandom}));
      test_random(455, 0, 68);
      write_csr(CSR_BUDGET, 54'($urandom_range(0, 1 << 22)));
      test_random(455, 33, 33);

      if (error_count == 0) begin
         $display("tb_lifetime_aliasing_block_allocator passed");
      end else begin
         $display("tb_lifetime_aliasing_block_allocator failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #30ms;
      $display("tb_lifetime_aliasing_block_allocator failed");
      $finish;
   end

endmodule
